// ===== hdl/pirl_pkg.sv =====
// Package for the positional insert/remove list.
// Holds the action codes and the command struct shared by the control unit,
// the cells and the top level. Depends on nothing.
package pirl_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // Decoded, already validated command for the current transaction.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic do_read;
    } pirl_cmd_t;

endpackage

// ===== hdl/pirl_cell.sv =====
// One storage cell of the list: holds a single element word.
// Shifts up or down with its neighbors and answers reads at its own index.
// Depends on pirl_pkg.
module pirl_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 6,
    parameter int SW    = 32
) (
    input  logic                clk,
    input  pirl_pkg::pirl_cmd_t cmd,
    input  logic [PW-1:0]       pos,
    input  logic [SW-1:0]       ins_data,
    input  logic [SW-1:0]       left_data,
    input  logic [SW-1:0]       right_data,
    output logic [SW-1:0]       data,
    output logic [SW-1:0]       rd_data
);

    logic [SW-1:0] data_reg;
    logic [SW-1:0] data_next;
    logic          at_pos;
    logic          above_pos;

    assign at_pos    = (pos == PW'(INDEX));
    assign above_pos = (pos < PW'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        if (cmd.do_insert)
        begin
            if (at_pos)
            begin
                data_next = ins_data;
            end
            else if (above_pos)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.do_remove)
        begin
            if (at_pos || above_pos)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.do_read && at_pos) ? data_reg : '0;

endmodule

// ===== hdl/pirl_ctrl.sv =====
// Control unit of the list: fill count, logical capacity and range checks.
// Produces the validated command for the cells and the values after it.
// Depends on pirl_pkg.
module pirl_ctrl #(
    parameter int DEPTH        = 16,
    parameter int MIN_CAPACITY = 4,
    parameter int CW           = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          action,
    input  logic [4:0]          position,
    output pirl_pkg::pirl_cmd_t cmd,
    output logic                ok,
    output logic [CW-1:0]       count_cur,
    output logic [CW-1:0]       capacity_cur,
    output logic [CW-1:0]       count_new,
    output logic [CW-1:0]       capacity_new
);

    localparam int XW       = ((CW > 5) ? CW : 5) + 1;
    localparam int MIN_CLIP = (MIN_CAPACITY > DEPTH) ? DEPTH : MIN_CAPACITY;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] capacity_reg;
    logic [CW-1:0] capacity_next;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] cap_dbl;
    logic [XW-1:0] cap_grown;
    logic [CW-1:0] cnt_dec;
    logic          insert_ok;
    logic          remove_ok;
    logic          read_ok;

    assign pos_x   = XW'(position);
    assign cnt_x   = XW'(count_reg);
    assign cap_x   = XW'(capacity_reg);
    assign cap_dbl = cap_x << 1;
    assign cnt_dec = count_reg - 1'b1;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_grown = XW'(MIN_CLIP);
        end
        else if (cap_dbl > XW'(DEPTH))
        begin
            cap_grown = XW'(DEPTH);
        end
        else
        begin
            cap_grown = cap_dbl;
        end
    end

    always_comb
    begin
        insert_ok = 1'b0;
        remove_ok = 1'b0;
        read_ok   = 1'b0;
        case (action)
            pirl_pkg::ACT_INSERT: insert_ok = (pos_x <= cnt_x) && (cnt_x != XW'(DEPTH));
            pirl_pkg::ACT_REMOVE: remove_ok = (pos_x < cnt_x);
            pirl_pkg::ACT_READ:   read_ok   = (pos_x < cnt_x);
            default:              ;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        capacity_next = capacity_reg;
        if (insert_ok)
        begin
            count_next = count_reg + 1'b1;
            if (count_reg >= capacity_reg)
            begin
                capacity_next = CW'(cap_grown);
            end
        end
        else if (remove_ok)
        begin
            count_next = cnt_dec;
            // Halve once under a quarter full, if half >= MIN_CAPACITY.
            if ((XW'(cnt_dec) < (cap_x >> 2)) && ((cap_x >> 1) >= XW'(MIN_CAPACITY)))
            begin
                capacity_next = CW'(cap_x >> 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= '0;
        end
        else if (fire)
        begin
            count_reg    <= count_next;
            capacity_reg <= capacity_next;
        end
    end

    assign cmd.do_insert = fire && insert_ok;
    assign cmd.do_remove = fire && remove_ok;
    assign cmd.do_read   = fire && read_ok;
    assign ok            = insert_ok || remove_ok || read_ok;
    assign count_cur     = count_reg;
    assign capacity_cur  = capacity_reg;
    assign count_new     = count_next;
    assign capacity_new  = capacity_next;

endmodule

// ===== hdl/positional_insert_remove_list.sv =====
// Top level of the positional insert/remove list: a chain of element cells,
// the control unit and the output register.
// Depends on pirl_pkg, pirl_cell and pirl_ctrl.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | into      | in_valid / in_stall  | action, position, element
//  out     | out of    | out_valid / out_stall| ok, read_data, count, capacity
//
// A transaction is done in the edge that accepts it: the cells shift or
// hold in that edge, and the result is registered and shown on the next
// cycle. The cell chain makes this possible: each cell decides its next
// word from its own index and the requested position.
// Reset (rst_n, asynchronous, active low) empties the list and clears the
// capacity; the stored words themselves are not cleared.
// The input stalls only while a result waits and the output is stalled.
module positional_insert_remove_list #(
    parameter int DEPTH        = 16,
    parameter int MIN_CAPACITY = 4,
    parameter int ELEMENT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [4:0]  position,
    input  logic [31:0] element,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [31:0] read_data,
    output logic [4:0]  count,
    output logic [4:0]  capacity
);

    // Count and capacity width, and a compare width that also holds the
    // five-bit position and a doubled capacity.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;
    localparam int SW = ELEMENT_BITS;

    pirl_pkg::pirl_cmd_t cmd;
    logic                fire;
    logic                ok_now;
    logic [CW-1:0]       count_cur;
    logic [CW-1:0]       capacity_cur;
    logic [CW-1:0]       count_new;
    logic [CW-1:0]       capacity_new;
    logic [PW-1:0]       pos_x;
    logic [PW-1:0]       count_x;
    logic [PW-1:0]       capacity_x;
    logic [SW-1:0]       elem_w;
    logic [SW-1:0]       cell_data [DEPTH];
    logic [SW-1:0]       cell_rd [DEPTH];
    logic [SW-1:0]       rd_word;
    logic [31:0]         rd_out;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                ok_reg;
    logic [31:0]         read_data_reg;
    logic [4:0]          count_reg;
    logic [4:0]          capacity_reg;

    // A transaction is taken unless a finished result is still held back.
    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;
    assign pos_x    = PW'(position);

    // The element port is 32 bits wide; the stored word keeps ELEMENT_BITS
    // of it, and the read word is widened or cut back to 32 bits.
    for (genvar b = 0; b < SW; b++)
    begin : g_elem
        if (b < 32)
        begin : g_in
            assign elem_w[b] = element[b];
        end
        else
        begin : g_zero
            assign elem_w[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < 32; b++)
    begin : g_rd
        if (b < SW)
        begin : g_in
            assign rd_out[b] = rd_word[b];
        end
        else
        begin : g_zero
            assign rd_out[b] = 1'b0;
        end
    end

    pirl_ctrl #(
        .DEPTH        (DEPTH),
        .MIN_CAPACITY (MIN_CAPACITY),
        .CW           (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .action       (action),
        .position     (position),
        .cmd          (cmd),
        .ok           (ok_now),
        .count_cur    (count_cur),
        .capacity_cur (capacity_cur),
        .count_new    (count_new),
        .capacity_new (capacity_new)
    );

    // The chain: each cell takes its left neighbor on an insert below it and
    // its right neighbor on a remove at or below it. The first cell's left
    // input is never selected; the last cell's right input is its own word.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [SW-1:0] left_w;
        logic [SW-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = elem_w;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pirl_cell #(
            .INDEX (i),
            .PW    (PW),
            .SW    (SW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_x),
            .ins_data   (elem_w),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // At most one cell answers a read; all others drive zero.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    assign count_x    = PW'(count_new);
    assign capacity_x = PW'(capacity_new);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg        <= ok_now;
            read_data_reg <= rd_out;
            count_reg     <= count_x[4:0];
            capacity_reg  <= capacity_x[4:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign read_data = read_data_reg;
    assign count     = count_reg;
    assign capacity  = capacity_reg;

`ifndef SYNTHESIS
    // An accepted transaction always shows a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("accepted transaction produced no result");

    // The list never holds more entries than its logical capacity, and the capacity never exceeds the depth.
    a_count_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (count_cur <= capacity_cur) && (capacity_cur <= CW'(DEPTH)))
        else $error("fill count exceeds capacity");

    // A done insert grows the count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> (count_cur == CW'($past(count_cur) + 1'b1)))
        else $error("insert did not advance the count");

    // A refused transaction reports a zero read word.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (read_data == '0))
        else $error("refused transaction returned data");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for positional_insert_remove_list.
// Runs a directed table and then random insert/remove/read traffic, checked against a local
// predictor of the list. Depends on pirl_pkg and the positional_insert_remove_list RTL.
module tb;

    localparam int LIST_DEPTH   = 16;
    localparam int LIST_MIN_CAP = 4;
    localparam int RANDOM_OPS   = 650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // Traffic mixes used by the random part.
    localparam int MIX_GROW     = 0;
    localparam int MIX_SHRINK   = 1;
    localparam int MIX_BALANCED = 2;

    // One result transaction as the output channel shows it.
    typedef struct packed {
        logic        ok;
        logic [31:0] data;
        logic [4:0]  count;
        logic [4:0]  cap;
    } list_result_t;

    // One row of the directed table. A row may be repeated; the element then
    // advances by one per repetition so that shifted entries stay distinct.
    // When "typed" is set, the hand-written result is checked instead of the
    // predicted one, though the predictor still tracks the operation.
    typedef struct packed {
        pirl_pkg::action_t act;
        logic [4:0]        pos;
        logic [31:0]       elem;
        logic [4:0]        reps;
        logic              typed;
        list_result_t      want;
    } dir_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    pirl_pkg::action_t action    = pirl_pkg::ACT_NOP;
    logic [4:0]        position  = '0;
    logic [31:0]       element   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              ok;
    logic [31:0]       read_data;
    logic [4:0]        count;
    logic [4:0]        capacity;

    // Predictor state: the list contents, its fill level and logical capacity.
    logic [31:0] list_words [LIST_DEPTH] = '{default: '0};
    int unsigned list_fill = 0;
    int unsigned list_cap  = 0;

    // Results that have been earned by accepted input transactions but not yet seen.
    list_result_t pending_results [$];

    int fail_count      = 0;
    int results_seen    = 0;
    int inserts_sent    = 0;
    int removes_sent    = 0;
    int reads_sent      = 0;
    int nops_sent       = 0;
    int full_refusals   = 0;
    int shrinks_seen    = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    int rx_wait         = 0;
    int hold_left       = 0;

    dir_row_t directed_rows [17];

    positional_insert_remove_list u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .position  (position),
        .element   (element),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .read_data (read_data),
        .count     (count),
        .capacity  (capacity)
    );

    always #1 clk = ~clk;

    // Applies one operation to the predicted list and returns the result the
    // block must report for it. Insert grows the logical capacity when the list
    // already fills it; remove halves it once the list drops below a quarter,
    // as long as the half stays at or above the minimum.
    function automatic list_result_t list_apply(input pirl_pkg::action_t op,
                                                input logic [4:0] pos,
                                                input logic [31:0] elem);
        list_result_t r;
        int unsigned  p;
        int unsigned  i;
        r = '0;
        p = pos;
        case (op)
            pirl_pkg::ACT_INSERT:
            begin
                if (p <= list_fill && list_fill < LIST_DEPTH)
                begin
                    if (list_fill >= list_cap)
                    begin
                        list_cap = (list_cap == 0) ? LIST_MIN_CAP : 2 * list_cap;
                        if (list_cap > LIST_DEPTH)
                            list_cap = LIST_DEPTH;
                    end
                    for (i = list_fill; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = elem;
                    list_fill++;
                    r.ok = 1'b1;
                end
            end
            pirl_pkg::ACT_REMOVE:
            begin
                if (p < list_fill)
                begin
                    for (i = p; i + 1 < list_fill; i++)
                        list_words[i] = list_words[i + 1];
                    list_fill--;
                    if (list_fill < list_cap / 4 && list_cap / 2 >= LIST_MIN_CAP)
                    begin
                        list_cap = list_cap / 2;
                        shrinks_seen++;
                    end
                    r.ok = 1'b1;
                end
            end
            pirl_pkg::ACT_READ:
            begin
                if (p < list_fill)
                begin
                    r.data = list_words[p];
                    r.ok   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = list_fill[4:0];
        r.cap   = list_cap[4:0];
        return r;
    endfunction

    // Offers one input transaction after a random gap, waits until the block
    // takes it, and then records the result it must produce. The gap is drawn
    // per item; in steady stretches the sender offers back to back.
    task automatic send_op(input pirl_pkg::action_t op, input logic [4:0] pos,
                           input logic [31:0] elem, input logic use_want,
                           input list_result_t want);
        int           gap;
        list_result_t predicted;
        gap = sender_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= op;
        position <= pos;
        element  <= elem;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == pirl_pkg::ACT_INSERT && list_fill == LIST_DEPTH)
            full_refusals++;
        case (op)
            pirl_pkg::ACT_INSERT: inserts_sent++;
            pirl_pkg::ACT_REMOVE: removes_sent++;
            pirl_pkg::ACT_READ:   reads_sent++;
            default:              nops_sent++;
        endcase
        predicted = list_apply(op, pos, elem);
        pending_results.push_back(use_want ? want : predicted);
    endtask

    // Picks a position that the current list accepts for the operation, or zero for
    // a remove or read on an empty list, with extra weight on both ends of the list.
    function automatic logic [4:0] legal_position(input pirl_pkg::action_t op);
        int unsigned top;
        int unsigned pick;
        if (op == pirl_pkg::ACT_INSERT)
            top = list_fill;
        else if (list_fill == 0)
            return 5'd0;
        else
            top = list_fill - 1;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return 5'd0;
        if (pick == 1)
            return top[4:0];
        return 5'($urandom_range(0, top));
    endfunction

    // Result side: checks each accepted result against the oldest expectation
    // and decides the stall for the coming cycle. The receiver draws a wait
    // after every result, and also stalls while the long hold below runs.
    always @(posedge clk)
    begin : result_check
        list_result_t seen;
        list_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {ok, read_data, count, capacity};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Unexpected result: ok=%0b data=%h count=%0d cap=%0d",
                                 seen.ok, seen.data, seen.count, seen.cap);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.ok !== want.ok || seen.data !== want.data ||
                        seen.count !== want.count || seen.cap !== want.cap)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("Result %0d mismatch: expected ok=%0b data=%h count=%0d cap=%0d",
                                     results_seen, want.ok, want.data, want.count, want.cap);
                            $display("    actual ok=%0b data=%h count=%0d cap=%0d",
                                     seen.ok, seen.data, seen.count, seen.cap);
                        end
                    end
                end
                if (results_seen % 50 == 0)
                    receiver_steady = ($urandom_range(0, 3) == 0);
                rx_wait = receiver_steady ? 0 : $urandom_range(0, 11);
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            out_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    // Long hold: once HOLD_AT results have been taken, the receiver refuses
    // results while a count loaded from HOLD_CYCLES runs down and the sender
    // keeps offering, so that the output register fills and the input backs
    // up. The count runs on the falling edge so that the result side reads a settled value.
    initial
    begin : long_hold
        wait (results_seen == HOLD_AT);
        @(negedge clk);
        hold_left = HOLD_CYCLES;
        while (hold_left > 0)
        begin
            @(negedge clk);
            hold_left--;
        end
    end

    // Stimulus: reset, the directed table, then random traffic in stretches
    // that favor growing, shrinking or a balanced mix, so that the list runs
    // into both its full and its empty end and the capacity moves both ways.
    initial
    begin : stimulus
        int                k;
        int                n;
        int                mix;
        int                roll;
        pirl_pkg::action_t op;
        logic [4:0]        pos;
        logic [31:0]       elem;

        // Directed part: empty-list refusals, the idle code, inserts at both
        // ends and past the end, filling to the depth limit with capacity growth,
        // an insert into the full list, and reads and removes out of range and at the ends.
        directed_rows = '{
            '{pirl_pkg::ACT_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_INSERT, 5'd1,  32'h1234_5678, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_NOP,    5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_INSERT, 5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1,
              {1'b1, 32'h0,         5'd1,  5'd4}},
            '{pirl_pkg::ACT_INSERT, 5'd1,  32'h0000_0000, 5'd1,  1'b1,
              {1'b1, 32'h0,         5'd2,  5'd4}},
            '{pirl_pkg::ACT_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b1,
              {1'b1, 32'hFFFF_FFFF, 5'd2,  5'd4}},
            '{pirl_pkg::ACT_INSERT, 5'd3,  32'h0000_0001, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd2,  5'd4}},
            '{pirl_pkg::ACT_INSERT, 5'd1,  32'hA5A5_A5A5, 5'd1,  1'b0,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_INSERT, 5'd0,  32'h0000_1000, 5'd13, 1'b0,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_INSERT, 5'd0,  32'hDEAD_BEEF, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd16, 5'd16}},
            '{pirl_pkg::ACT_READ,   5'd15, 32'h0000_0000, 5'd1,  1'b0,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_READ,   5'd16, 32'h0000_0000, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd16, 5'd16}},
            '{pirl_pkg::ACT_REMOVE, 5'd31, 32'h0000_0000, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd16, 5'd16}},
            '{pirl_pkg::ACT_REMOVE, 5'd15, 32'h0000_0000, 5'd1,  1'b0,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b0,
              {1'b0, 32'h0,         5'd0,  5'd0}},
            '{pirl_pkg::ACT_NOP,    5'd0,  32'h5555_AAAA, 5'd1,  1'b1,
              {1'b0, 32'h0,         5'd14, 5'd16}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (k = 0; k < directed_rows[r].reps; k++)
            begin
                send_op(directed_rows[r].act, directed_rows[r].pos,
                        directed_rows[r].elem + 32'(k), directed_rows[r].typed,
                        directed_rows[r].want);
            end
        end

        mix = MIX_BALANCED;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 40 == 0)
            begin
                mix = $urandom_range(MIX_GROW, MIX_BALANCED);
                sender_steady = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                // Noise: any code, any position the field can carry.
                op  = pirl_pkg::action_t'($urandom_range(0, 3));
                pos = 5'($urandom_range(0, 31));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:
                        op = (roll < 65) ? pirl_pkg::ACT_INSERT :
                             (roll < 80) ? pirl_pkg::ACT_REMOVE : pirl_pkg::ACT_READ;
                    MIX_SHRINK:
                        op = (roll < 20) ? pirl_pkg::ACT_INSERT :
                             (roll < 75) ? pirl_pkg::ACT_REMOVE : pirl_pkg::ACT_READ;
                    default:
                        op = (roll < 40) ? pirl_pkg::ACT_INSERT :
                             (roll < 75) ? pirl_pkg::ACT_REMOVE : pirl_pkg::ACT_READ;
                endcase
                pos = legal_position(op);
            end
            roll = $urandom_range(0, 9);
            if (roll == 0)
                elem = 32'h0000_0000;
            else if (roll == 1)
                elem = 32'hFFFF_FFFF;
            else
                elem = $urandom;
            send_op(op, pos, elem, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d removes, %0d reads and %0d idle codes;",
                 inserts_sent, removes_sent, reads_sent, nops_sent);
        $display("%0d results checked, %0d full-list refusals, %0d capacity halvings.",
                 results_seen, full_refusals, shrinks_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a hung handshake or lost result ends the run here.
    initial
    begin : watchdog
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge clk);
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
